// ----- src/sle_pkg.sv -----
// Shared types and codes for the sequential list engine.
`timescale 1ns / 1ps

package sle_pkg;

	localparam int CMD_W    = 3;
	localparam int KEY_W    = 64;
	localparam int QTY_W    = 32;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 3;
	localparam int LEN_W    = 5;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Command codes
	localparam cmd_t CMD_INS_FRONT = 3'd0;
	localparam cmd_t CMD_INS_BACK  = 3'd1;
	localparam cmd_t CMD_DEL_FRONT = 3'd2;
	localparam cmd_t CMD_DEL_BACK  = 3'd3;
	localparam cmd_t CMD_DEL_POS   = 3'd4;
	localparam cmd_t CMD_SEARCH    = 3'd5;

	// Status codes
	localparam status_t ST_OK     = 3'd0;
	localparam status_t ST_FULL   = 3'd1;
	localparam status_t ST_EMPTY  = 3'd2;
	localparam status_t ST_MISS   = 3'd3;
	localparam status_t ST_BADCMD = 3'd4;

	// One stored list entry
	typedef struct packed {
		logic [KEY_W-1:0]        key;
		logic signed [QTY_W-1:0] qty;
	} entry_t;

endpackage

// ----- src/sequential_list_engine.sv -----
// Ordered key/quantity list with one-entry-per-cycle shifting and search.
//
// Usage:
//   Commands arrive on the input channel (in_valid / in_stall) with a command
//   code, a 64-bit key, a signed quantity and a position. Each command gives
//   exactly one result on the output channel (out_valid / out_stall): status,
//   found flag, found quantity and list length after the command.
//   Entries live in a single-port-write, single-port-read memory with a
//   registered read, so every move or compare visits one entry per cycle.
//   Insert back, delete back, any error and an insert into an empty list
//   need no walk. Insert front moves every entry up one place, last first,
//   then writes the new front entry. Delete at front or position p moves
//   the entries above p down one place; deleting the last entry needs no
//   move. Search compares from the front and stops at the first match.
//   One command is worked on at a time; in_stall stays high while it runs.
//   The next command is taken as the result transfers, or earlier when the
//   result register is already empty.
//   If the receiver stalls, the result holds in its register and in_stall
//   stays high until it transfers.
//   Reset empties the list and drops any pending result; entry contents are
//   not cleared since only entries below the length are ever read.
`timescale 1ns / 1ps

module sequential_list_engine
	import sle_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CMD_W-1:0]        command,
	input  logic [KEY_W-1:0]        item_key,
	input  logic signed [QTY_W-1:0] item_quantity,
	input  logic [POS_W-1:0]        position,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [STATUS_W-1:0]     status,
	output logic                    found,
	output logic signed [QTY_W-1:0] found_quantity,
	output logic [LEN_W-1:0]        list_length
);

	localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_DRAIN,
		S_PUT_FRONT,
		S_SEARCH
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           cnt_q;
	logic [AW-1:0]           idx_q;
	logic                    op_front_q;
	logic [KEY_W-1:0]        key_q;
	logic signed [QTY_W-1:0] qty_q;

	// Read pipeline
	entry_t                  mem [CAPACITY];
	entry_t                  rdata_q;
	logic                    pend_q;
	logic                    pend_wr_q;
	logic [AW-1:0]           pend_addr_q;

	// Result register
	logic                    out_valid_q;
	status_t                 status_q;
	logic                    found_q;
	logic signed [QTY_W-1:0] found_qty_q;
	logic [LEN_W-1:0]        length_q;

	logic                    in_fire;
	logic                    out_fire;
	logic                    full;
	logic                    empty;
	logic [AW-1:0]           last_idx;
	logic [CW-1:0]           cnt_inc;
	logic [CW-1:0]           cnt_dec;
	logic                    pos_bad;
	logic                    pos_last;
	logic                    key_hit;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	entry_t                  wr_data;

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid_q && !out_stall;

	assign full     = (cnt_q == CW'(CAPACITY));
	assign empty    = (cnt_q == '0);
	assign cnt_inc  = cnt_q + 1'b1;
	assign cnt_dec  = cnt_q - 1'b1;
	assign last_idx = AW'(cnt_dec);
	assign pos_bad  = (CMPW'(position) >= CMPW'(cnt_q));
	assign pos_last = (CMPW'(position) == CMPW'(cnt_dec));
	assign key_hit  = (rdata_q.key == key_q);

	// Single write port: moved entry, new front entry, or direct insert
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pend_addr_q;
		wr_data = rdata_q;
		if (pend_wr_q) begin
			wr_en = 1'b1;
		end else if (state_q == S_PUT_FRONT) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = '{key: key_q, qty: qty_q};
		end else if (in_fire && !full && ((command == CMD_INS_BACK) ||
				(command == CMD_INS_FRONT && empty))) begin
			wr_en   = 1'b1;
			wr_addr = AW'(cnt_q);
			wr_data = '{key: item_key, qty: item_quantity};
		end
	end

	// Entry memory, registered read at the walking index
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[idx_q];
	end

	// Track what the registered read data stands for
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= 1'b0;
			pend_wr_q <= 1'b0;
		end else begin
			pend_q    <= (state_q == S_SEARCH);
			pend_wr_q <= (state_q == S_SHIFT_UP) || (state_q == S_SHIFT_DN);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_SHIFT_UP: pend_addr_q <= AW'(idx_q + 1'b1);
			S_SHIFT_DN: pend_addr_q <= AW'(idx_q - 1'b1);
			default:    pend_addr_q <= idx_q;
		endcase
	end

	// Sequencer, list length and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			op_front_q  <= 1'b0;
			key_q       <= '0;
			qty_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			found_q     <= 1'b0;
			found_qty_q <= '0;
			length_q    <= '0;
		end else begin
			if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						key_q       <= item_key;
						qty_q       <= item_quantity;
						found_q     <= 1'b0;
						found_qty_q <= '0;
						status_q    <= ST_OK;
						length_q    <= LEN_W'(cnt_q);
						out_valid_q <= 1'b1;
						unique case (command)
							CMD_INS_FRONT: begin
								if (full) begin
									status_q <= ST_FULL;
								end else if (empty) begin
									cnt_q    <= cnt_inc;
									length_q <= LEN_W'(cnt_inc);
								end else begin
									out_valid_q <= 1'b0;
									op_front_q  <= 1'b1;
									idx_q       <= last_idx;
									state_q     <= S_SHIFT_UP;
								end
							end
							CMD_INS_BACK: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									cnt_q    <= cnt_inc;
									length_q <= LEN_W'(cnt_inc);
								end
							end
							CMD_DEL_BACK: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									cnt_q    <= cnt_dec;
									length_q <= LEN_W'(cnt_dec);
								end
							end
							CMD_DEL_FRONT, CMD_DEL_POS: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else if (command == CMD_DEL_FRONT) begin
									if (cnt_q == CW'(1)) begin
										cnt_q    <= cnt_dec;
										length_q <= LEN_W'(cnt_dec);
									end else begin
										out_valid_q <= 1'b0;
										op_front_q  <= 1'b0;
										idx_q       <= AW'(1);
										state_q     <= S_SHIFT_DN;
									end
								end else if (pos_bad) begin
									status_q <= ST_MISS;
								end else if (pos_last) begin
									cnt_q    <= cnt_dec;
									length_q <= LEN_W'(cnt_dec);
								end else begin
									out_valid_q <= 1'b0;
									op_front_q  <= 1'b0;
									idx_q       <= AW'(AW'(position) + 1'b1);
									state_q     <= S_SHIFT_DN;
								end
							end
							CMD_SEARCH: begin
								if (empty) begin
									status_q <= ST_MISS;
								end else begin
									out_valid_q <= 1'b0;
									idx_q       <= '0;
									state_q     <= S_SEARCH;
								end
							end
							default: begin
								status_q <= ST_BADCMD;
							end
						endcase
					end
				end
				// Move entries up one place, last entry first
				S_SHIFT_UP: begin
					if (idx_q == '0) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				// Move entries down one place toward the front, walking toward the tail
				S_SHIFT_DN: begin
					if (idx_q == last_idx) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				// Last moved entry is written this cycle
				S_DRAIN: begin
					if (op_front_q) begin
						state_q <= S_PUT_FRONT;
					end else begin
						cnt_q       <= cnt_dec;
						length_q    <= LEN_W'(cnt_dec);
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_PUT_FRONT: begin
					cnt_q       <= cnt_inc;
					length_q    <= LEN_W'(cnt_inc);
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				// Compare one entry per cycle, stop at the first hit
				S_SEARCH: begin
					if (idx_q != last_idx) begin
						idx_q <= idx_q + 1'b1;
					end
					if (pend_q && key_hit) begin
						found_q     <= 1'b1;
						found_qty_q <= rdata_q.qty;
						status_q    <= ST_OK;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (pend_q && pend_addr_q == last_idx) begin
						status_q    <= ST_MISS;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found          = found_q;
	assign found_quantity = found_qty_q;
	assign list_length    = length_q;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("list length above capacity");

	a_no_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		pend_wr_q |-> !in_fire && (state_q != S_PUT_FRONT))
		else $error("two writes to the entry memory in one cycle");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q |-> status_q == ST_OK)
		else $error("found result without ok status");

	a_put_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT_FRONT) |-> !full)
		else $error("front insert into a full list");

	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH || state_q == S_SHIFT_UP || state_q == S_SHIFT_DN)
			|-> !out_valid_q)
		else $error("result pending while a command is running");

endmodule

// ----- tb/sv/sequential_list_engine_test.sv -----
// Self-checking testbench for the sequential list engine.
`timescale 1ns / 1ps

module sequential_list_engine_test;
	import sle_pkg::*;

	localparam int CAPACITY = 16;
	localparam int POOL_SIZE = 8;
	localparam int RANDOM_PER_PHASE = 480;
	localparam int SETTLE_CYCLES = 40;

	// Command codes the engine does not decode
	localparam cmd_t CMD_UNUSED_6 = 3'd6;
	localparam cmd_t CMD_UNUSED_7 = 3'd7;

	localparam logic signed [QTY_W-1:0] QTY_MIN = 32'sh8000_0000;
	localparam logic signed [QTY_W-1:0] QTY_MAX = 32'sh7fff_ffff;

	typedef struct {
		status_t                 status;
		logic                    found;
		logic signed [QTY_W-1:0] quantity;
		logic [LEN_W-1:0]        length;
	} list_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [CMD_W-1:0]        command = '0;
	logic [KEY_W-1:0]        item_key = '0;
	logic signed [QTY_W-1:0] item_quantity = '0;
	logic [POS_W-1:0]        position = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [STATUS_W-1:0]     status;
	logic                    found;
	logic signed [QTY_W-1:0] found_quantity;
	logic [LEN_W-1:0]        list_length;

	// Predicted list contents
	logic [KEY_W-1:0]        model_keys [CAPACITY];
	logic signed [QTY_W-1:0] model_qtys [CAPACITY];
	int                      model_count = 0;

	list_result_t            pending_results [$];
	logic [KEY_W-1:0]        key_pool [POOL_SIZE];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int commands_sent = 0;
	int search_hits = 0;
	int status_tally [5] = '{default: 0};

	sequential_list_engine #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.item_key(item_key),
		.item_quantity(item_quantity),
		.position(position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.found(found),
		.found_quantity(found_quantity),
		.list_length(list_length)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver back-pressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Apply one command to the predicted list and return the expected result
	function automatic list_result_t apply_list_command(input cmd_t cmd,
			input logic [KEY_W-1:0] key, input logic signed [QTY_W-1:0] qty,
			input logic [POS_W-1:0] pos);
		list_result_t r;
		int first;
		r = '{status: ST_OK, found: 1'b0, quantity: '0, length: '0};
		case (cmd)
			CMD_INS_FRONT, CMD_INS_BACK: begin
				if (model_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (cmd == CMD_INS_FRONT) begin
					for (int i = model_count; i > 0; i--) begin
						model_keys[i] = model_keys[i-1];
						model_qtys[i] = model_qtys[i-1];
					end
					model_keys[0] = key;
					model_qtys[0] = qty;
					model_count++;
				end else begin
					model_keys[model_count] = key;
					model_qtys[model_count] = qty;
					model_count++;
				end
			end
			CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
				if (model_count == 0) begin
					r.status = ST_EMPTY;
				end else if (cmd == CMD_DEL_POS && pos >= model_count) begin
					r.status = ST_MISS;
				end else begin
					first = (cmd == CMD_DEL_FRONT) ? 0 :
						(cmd == CMD_DEL_BACK) ? model_count - 1 : int'(pos);
					for (int i = first + 1; i < model_count; i++) begin
						model_keys[i-1] = model_keys[i];
						model_qtys[i-1] = model_qtys[i];
					end
					model_count--;
				end
			end
			CMD_SEARCH: begin
				// First matching entry wins
				r.status = ST_MISS;
				for (int i = 0; i < model_count && !r.found; i++) begin
					if (model_keys[i] == key) begin
						r.status = ST_OK;
						r.found = 1'b1;
						r.quantity = model_qtys[i];
					end
				end
			end
			default: begin
				r.status = ST_BADCMD;
			end
		endcase
		r.length = LEN_W'(model_count);
		return r;
	endfunction

	// Drive one command and hold it until the engine takes the transfer
	task automatic send_command(input cmd_t cmd, input logic [KEY_W-1:0] key,
			input logic signed [QTY_W-1:0] qty, input logic [POS_W-1:0] pos);
		list_result_t exp;
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		item_key <= key;
		item_quantity <= qty;
		position <= pos;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !in_stall;
			if (taken) begin
				exp = apply_list_command(cmd, key, qty, pos);
				pending_results.push_back(exp);
				commands_sent++;
				status_tally[exp.status]++;
				if (exp.found)
					search_hits++;
			end
			@(negedge clk);
		end
	endtask

	// Hold off the sender until every outstanding result has come back
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [KEY_W-1:0] random_key();
		return {$urandom, $urandom};
	endfunction

	function automatic logic signed [QTY_W-1:0] random_quantity();
		case ($urandom_range(9))
			0: return QTY_MIN;
			1: return QTY_MAX;
			default: return $urandom;
		endcase
	endfunction

	// Compare each result transfer against the oldest prediction
	always @(posedge clk) begin : result_check
		list_result_t exp;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no command outstanding: status %0d", status);
				error_count++;
			end else begin
				exp = pending_results.pop_front();
				if (status !== exp.status) begin
					$error("status: expected %0d, got %0d", exp.status, status);
					error_count++;
				end
				if (found !== exp.found) begin
					$error("found: expected %0d, got %0d", exp.found, found);
					error_count++;
				end
				if (found_quantity !== exp.quantity) begin
					$error("found_quantity: expected %0d, got %0d", exp.quantity,
						found_quantity);
					error_count++;
				end
				if (list_length !== exp.length) begin
					$error("list_length: expected %0d, got %0d", exp.length, list_length);
					error_count++;
				end
			end
		end
	end

	// Every delete and search on an empty list
	task automatic test_empty_list();
		send_command(CMD_DEL_FRONT, random_key(), random_quantity(), 4'd0);
		send_command(CMD_DEL_BACK, random_key(), random_quantity(), 4'd15);
		send_command(CMD_DEL_POS, random_key(), random_quantity(), 4'd0);
		send_command(CMD_SEARCH, random_key(), random_quantity(), 4'd0);
	endtask

	task automatic test_unknown_commands();
		send_command(CMD_UNUSED_6, '1, QTY_MAX, 4'd15);
		send_command(CMD_UNUSED_7, '0, QTY_MIN, 4'd0);
	endtask

	// Key and quantity extremes, search hits and misses, position range
	task automatic test_field_extremes();
		send_command(CMD_INS_BACK, '0, QTY_MIN, 4'd15);
		send_command(CMD_INS_FRONT, '1, QTY_MAX, 4'd0);
		send_command(CMD_SEARCH, '1, random_quantity(), 4'd7);
		send_command(CMD_SEARCH, '0, random_quantity(), 4'd7);
		send_command(CMD_SEARCH, 64'h5555_aaaa_5555_aaaa, random_quantity(), 4'd0);
		send_command(CMD_DEL_POS, random_key(), random_quantity(), 4'd15);
		send_command(CMD_DEL_POS, random_key(), random_quantity(), 4'd1);
	endtask

	// Fill to capacity, then insert at both ends of a full list
	task automatic test_full_list();
		while (model_count < CAPACITY)
			send_command(model_count[0] ? CMD_INS_FRONT : CMD_INS_BACK, random_key(),
				random_quantity(), 4'($urandom));
		send_command(CMD_INS_FRONT, random_key(), random_quantity(), 4'd0);
		send_command(CMD_INS_BACK, random_key(), random_quantity(), 4'd0);
	endtask

	// Random walk between empty and full with searches on held keys
	task automatic run_random_commands(input int count);
		bit growing;
		int roll;
		cmd_t cmd;
		logic [KEY_W-1:0] key;
		logic [POS_W-1:0] pos;
		growing = 1'b1;
		for (int n = 0; n < count; n++) begin
			if (model_count == CAPACITY && $urandom_range(3) == 0)
				growing = 1'b0;
			if (model_count == 0 && $urandom_range(3) == 0)
				growing = 1'b1;
			roll = $urandom_range(99);
			if (roll < (growing ? 45 : 15))
				cmd = $urandom_range(1) ? CMD_INS_FRONT : CMD_INS_BACK;
			else if (roll < 60)
				cmd = (roll % 3 == 0) ? CMD_DEL_FRONT : (roll % 3 == 1) ? CMD_DEL_BACK :
					CMD_DEL_POS;
			else if (roll < 95)
				cmd = CMD_SEARCH;
			else
				cmd = $urandom_range(1) ? CMD_UNUSED_6 : CMD_UNUSED_7;

			// Keys repeat often so searches hit duplicates and the first match
			roll = $urandom_range(99);
			if (cmd == CMD_SEARCH && roll < 50 && model_count > 0)
				key = model_keys[$urandom_range(model_count - 1)];
			else if (roll < 75)
				key = key_pool[$urandom_range(POOL_SIZE - 1)];
			else
				key = random_key();

			if (model_count > 0 && $urandom_range(3) != 0)
				pos = POS_W'($urandom_range(model_count - 1));
			else
				pos = POS_W'($urandom);

			send_command(cmd, key, random_quantity(), pos);
		end
	endtask

	initial begin
		foreach (key_pool[i])
			key_pool[i] = random_key();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_list();
		test_unknown_commands();
		test_field_extremes();
		test_full_list();
		wait_for_drain();

		// Pacing phases: free-running, sender gaps, receiver stalls, both
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random_commands(RANDOM_PER_PHASE);
		wait_for_drain();
		send_idle_pct = 55;
		run_random_commands(RANDOM_PER_PHASE);
		wait_for_drain();
		send_idle_pct = 0;
		recv_stall_pct = 55;
		run_random_commands(RANDOM_PER_PHASE);
		wait_for_drain();
		send_idle_pct = 21;
		recv_stall_pct = 21;
		run_random_commands(RANDOM_PER_PHASE);

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Covered %0d commands: %0d ok, %0d full, %0d empty, %0d miss/range, %0d unknown",
			commands_sent, status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
			status_tally[ST_MISS], status_tally[ST_BADCMD]);
		$display("Search hits: %0d, under free-running, gapped, stalled and mixed pacing",
			search_hits);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/sle_pkg.sv
src/sequential_list_engine.sv
tb/sv/sequential_list_engine_test.sv
